// ----- rtl/core/srrw_pkg.sv -----
package srrw_pkg;

    localparam int WINDOW_MAX = 32;
    localparam int REF_WIDTH = 16;
    localparam int SLOT_W = $clog2(WINDOW_MAX);
    localparam int WIN_W = 6;
    localparam int SEQ_W = 16;
    localparam int LEN_W = 13;
    localparam logic [15:0] SUM_ALL_ONES = 16'hffff;
    localparam int FLAG_IN_USE_BIT = 0;
    localparam int FLAG_EOF_BIT = 4;

    localparam logic KIND_ACK = 1'b0;
    localparam logic KIND_DELIVER = 1'b1;

    typedef struct packed {
        logic [31:0]          src_ip;
        logic [31:0]          dst_ip;
        logic [15:0]          src_port;
        logic [15:0]          dst_port;
        logic [SEQ_W-1:0]     seq;
        logic [15:0]          ack_number;
        logic [15:0]          flags;
        logic [15:0]          packet_count;
        logic [LEN_W-1:0]     payload_length;
        logic [15:0]          checksum;
        logic [REF_WIDTH-1:0] payload_ref;
    } in_item_t;

    typedef struct packed {
        logic                 kind;
        logic [SEQ_W-1:0]     out_seq;
        logic [REF_WIDTH-1:0] out_ref;
        logic [LEN_W-1:0]     out_length;
        logic                 is_end;
        logic                 last;
    } out_item_t;

    typedef struct packed {
        logic [REF_WIDTH-1:0] ref_h;
        logic [LEN_W-1:0]     len;
        logic                 eof;
    } slot_t;

endpackage

// ----- rtl/core/srrw_hdr_check.sv -----
// Registered ones'-complement header check: the sum is registered on load, then folded and compared combinationally.
module srrw_hdr_check (
    input  logic              aclk,
    input  logic              load,
    input  srrw_pkg::in_item_t hdr,
    output logic              pass
);
    logic [19:0] sum_reg;
    logic [15:0] csum_reg;
    logic [16:0] fold1;
    logic [15:0] fold2;

    always_ff @(posedge aclk) begin
        if (load) begin
            sum_reg <= 20'(hdr.src_ip[15:0]) + 20'(hdr.src_ip[31:16])
                     + 20'(hdr.dst_ip[15:0]) + 20'(hdr.dst_ip[31:16])
                     + 20'(hdr.src_port) + 20'(hdr.dst_port) + 20'(hdr.seq)
                     + 20'(hdr.ack_number) + 20'(hdr.flags) + 20'(hdr.packet_count);
            csum_reg <= hdr.checksum;
        end
    end

    // Two folds always suffice for a 20-bit sum of ten words.
    assign fold1 = 17'(sum_reg[15:0]) + 17'(sum_reg[19:16]);
    assign fold2 = fold1[15:0] + 16'(fold1[16]);
    assign pass = ({1'b0, fold2} + {1'b0, csum_reg}) == {1'b0, srrw_pkg::SUM_ALL_ONES};
endmodule

// ----- rtl/core/selective_repeat_receive_window.sv -----
// An accepted item is checked in ST_CHECK, which registers its ack result or moves on
// to ST_RD; an item that causes no result returns to ST_IDLE, which frees the input.
// A new item is taken only in ST_IDLE; an ack adds the ST_ACK handshake, each delivery
// a slot read (ST_RD), result build and handshake (ST_OUT), held while m_ready stays low.
// A window write holds the input off while ST_MOD rebuilds the slot index.
// Reset clears base, slot valid flags and done flag and sets the window size to 1.
module selective_repeat_receive_window (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  srrw_pkg::in_item_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output srrw_pkg::out_item_t   m_data,
    input  logic                  cfg_we,
    input  logic [srrw_pkg::WIN_W-1:0] cfg_wdata
);
    typedef enum logic [2:0] {ST_IDLE, ST_CHECK, ST_ACK, ST_RD, ST_OUT, ST_MOD} state_t;

    state_t state_reg;
    logic [srrw_pkg::WIN_W-1:0] win_cfg_reg;
    logic [15:0] base_reg;
    logic [srrw_pkg::WINDOW_MAX-1:0] valid_reg;
    logic done_reg;
    srrw_pkg::in_item_t hdr_reg;
    srrw_pkg::slot_t slot_mem [srrw_pkg::WINDOW_MAX];
    srrw_pkg::slot_t rd_reg;
    logic [srrw_pkg::SLOT_W-1:0] pos_idx_reg;
    logic [srrw_pkg::SLOT_W:0] steps_reg;
    logic [srrw_pkg::SLOT_W-1:0] cur_idx_reg;
    logic [16:0] rem_reg;
    logic [4:0] bit_reg;
    logic pass;

    logic [srrw_pkg::SLOT_W:0] w;
    logic [16:0] hi_bound;
    logic in_win;
    logic [16:0] pos;
    logic [srrw_pkg::SLOT_W-1:0] seq_idx, pos_idx;
    logic [15:0] seq_diff;
    logic [srrw_pkg::SLOT_W:0] seq_off;
    logic [srrw_pkg::SLOT_W+1:0] seq_sum;
    logic [srrw_pkg::SLOT_W:0] inc_idx;
    logic [srrw_pkg::SLOT_W-1:0] adv_idx;
    logic ack_last, dlv_last;
    logic [22:0] mod_div;
    logic [16:0] rem_sub;

    srrw_hdr_check u_chk (.aclk(aclk), .load(s_valid && s_ready), .hdr(s_data), .pass(pass));

    always_comb begin
        if (win_cfg_reg == '0) w = (srrw_pkg::SLOT_W+1)'(1);
        else if (32'(win_cfg_reg) > srrw_pkg::WINDOW_MAX) w = (srrw_pkg::SLOT_W+1)'(srrw_pkg::WINDOW_MAX);
        else w = (srrw_pkg::SLOT_W+1)'(win_cfg_reg);
    end

    assign hi_bound = {1'b0, base_reg} + 17'(w);
    assign in_win = ({1'b0, hdr_reg.seq} > {1'b0, base_reg}) && ({1'b0, hdr_reg.seq} <= hi_bound);
    assign pos = {1'b0, base_reg} + 17'd1;

    // cur_idx_reg tracks (base + 1) mod window. A sequence number inside the window
    // lies less than one window above that position, so one subtraction wraps it.
    assign pos_idx = cur_idx_reg;
    assign seq_diff = hdr_reg.seq - base_reg - 16'd1;
    assign seq_off = seq_diff[srrw_pkg::SLOT_W:0];
    assign seq_sum = (srrw_pkg::SLOT_W+2)'(cur_idx_reg) + (srrw_pkg::SLOT_W+2)'(seq_off);
    assign seq_idx = (seq_sum >= (srrw_pkg::SLOT_W+2)'(w))
                     ? srrw_pkg::SLOT_W'(seq_sum - (srrw_pkg::SLOT_W+2)'(w))
                     : seq_sum[srrw_pkg::SLOT_W-1:0];

    // When the base wraps to zero the next position is 1, not 65537.
    assign inc_idx = (srrw_pkg::SLOT_W+1)'(cur_idx_reg) + (srrw_pkg::SLOT_W+1)'(1);
    assign adv_idx = (base_reg == 16'hffff)
                     ? ((w == (srrw_pkg::SLOT_W+1)'(1)) ? srrw_pkg::SLOT_W'(0)
                                                        : srrw_pkg::SLOT_W'(1))
                     : ((inc_idx == w) ? srrw_pkg::SLOT_W'(0)
                                       : inc_idx[srrw_pkg::SLOT_W-1:0]);

    assign ack_last = !(valid_reg[pos_idx] || (in_win && seq_idx == pos_idx));
    assign dlv_last = rd_reg.eof || ((steps_reg + (srrw_pkg::SLOT_W+1)'(1)) >= w)
                      || !valid_reg[adv_idx] || (adv_idx == pos_idx);

    // Restoring reduction of (base + 1) by the window, one quotient bit per cycle.
    assign mod_div = 23'(w) << bit_reg;
    assign rem_sub = (23'(rem_reg) >= mod_div) ? 17'(23'(rem_reg) - mod_div) : rem_reg;

    assign s_ready = (state_reg == ST_IDLE) && !cfg_we;

    logic do_store;
    assign do_store = (state_reg == ST_CHECK) && pass && hdr_reg.flags[srrw_pkg::FLAG_IN_USE_BIT]
                      && in_win;

    always_ff @(posedge aclk) begin
        if (do_store) begin
            slot_mem[seq_idx] <= '{ref_h: hdr_reg.payload_ref, len: hdr_reg.payload_length,
                                  eof: hdr_reg.flags[srrw_pkg::FLAG_EOF_BIT]};
        end
        if (s_valid && s_ready) hdr_reg <= s_data;
        rd_reg <= slot_mem[pos_idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            win_cfg_reg <= srrw_pkg::WIN_W'(1);
            base_reg <= '0;
            valid_reg <= '0;
            done_reg <= 1'b0;
            m_valid <= 1'b0;
            steps_reg <= '0;
            cur_idx_reg <= '0;
        end else begin
            if (cfg_we) win_cfg_reg <= cfg_wdata;
            if (do_store) valid_reg[seq_idx] <= 1'b1;
            unique case (state_reg)
                ST_IDLE: begin
                    if (cfg_we) begin
                        rem_reg <= pos;
                        bit_reg <= 5'd16;
                        state_reg <= ST_MOD;
                    end else if (s_valid && !done_reg) begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_MOD: begin
                    rem_reg <= rem_sub;
                    if (bit_reg == 5'd0) begin
                        cur_idx_reg <= rem_sub[srrw_pkg::SLOT_W-1:0];
                        state_reg <= ST_IDLE;
                    end else begin
                        bit_reg <= bit_reg - 5'd1;
                    end
                end
                ST_CHECK: begin
                    steps_reg <= '0;
                    if (pass && hdr_reg.flags[srrw_pkg::FLAG_IN_USE_BIT]) begin
                        m_valid <= 1'b1;
                        m_data <= '{kind: srrw_pkg::KIND_ACK, out_seq: hdr_reg.seq, out_ref: '0,
                                    out_length: '0, is_end: 1'b0, last: ack_last};
                        state_reg <= ST_ACK;
                    end else if (valid_reg[pos_idx]) begin
                        state_reg <= ST_RD;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_ACK: begin
                    if (m_ready) begin
                        m_valid <= 1'b0;
                        state_reg <= m_data.last ? ST_IDLE : ST_RD;
                    end
                end
                ST_RD: begin
                    pos_idx_reg <= pos_idx;
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_valid) begin
                        valid_reg[pos_idx_reg] <= 1'b0;
                        m_valid <= 1'b1;
                        m_data <= '{kind: srrw_pkg::KIND_DELIVER, out_seq: pos[15:0],
                                    out_ref: rd_reg.ref_h, out_length: rd_reg.len,
                                    is_end: rd_reg.eof, last: dlv_last};
                        steps_reg <= steps_reg + 1'b1;
                        if (rd_reg.eof) begin
                            done_reg <= 1'b1;
                        end else begin
                            base_reg <= base_reg + 16'd1;
                            cur_idx_reg <= adv_idx;
                        end
                    end else if (m_ready) begin
                        m_valid <= 1'b0;
                        state_reg <= m_data.last ? ST_IDLE : ST_RD;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Results only leave while an item is in flight.
    a_out_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (state_reg != ST_IDLE && state_reg != ST_CHECK))
        else $error("result valid outside item processing");
    a_no_accept_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && done_reg) |=> state_reg == ST_IDLE)
        else $error("item processed after transfer done");
    a_base_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (base_reg != $past(base_reg)) |-> $past(state_reg) == ST_OUT)
        else $error("window base moved outside delivery");
endmodule
